@@ rtl/core/sps_pkg.sv @@
// ----------------------------------------------------------------------------
// sps_pkg: shared types and constants of the stepper position sequencer
// Command codes, position width, register map and coil step tables.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

  // Width of the shared position and target registers (8 .. 32).
  localparam int unsigned POSITION_BITS = 16;

  // Width of the amount and reported position fields.
  localparam int unsigned FIELD_BITS = 16;

  // Configuration port.
  localparam int unsigned ADDR_BITS = 3;
  localparam int unsigned DATA_BITS = 32;
  localparam logic        REG_HALF_STEP_MODE = 1'b0;  // register index, paddr[2]

  typedef logic signed [POSITION_BITS-1:0] pos_t;
  typedef logic [3:0] coil_t;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_MOVE_BY = 3'd1,
    OP_GO_TO   = 3'd2,
    OP_SET_POS = 3'd3,
    OP_ENABLE  = 3'd4,
    OP_DISABLE = 3'd5
  } op_t;

  // Half-step sequence, indexed by position bits [2:0].
  function automatic coil_t half_step_pattern(input logic [2:0] idx);
    coil_t pat;
    case (idx)
      3'd0:    pat = 4'b0010;
      3'd1:    pat = 4'b1010;
      3'd2:    pat = 4'b1000;
      3'd3:    pat = 4'b1001;
      3'd4:    pat = 4'b0001;
      3'd5:    pat = 4'b0101;
      3'd6:    pat = 4'b0100;
      3'd7:    pat = 4'b0110;
      default: pat = 4'b0000;
    endcase
    return pat;
  endfunction

  // Full-step sequence, indexed by position bits [1:0].
  function automatic coil_t full_step_pattern(input logic [1:0] idx);
    coil_t pat;
    case (idx)
      2'd0:    pat = 4'b0010;
      2'd1:    pat = 4'b1000;
      2'd2:    pat = 4'b0001;
      2'd3:    pat = 4'b0100;
      default: pat = 4'b0000;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/stepper_position_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// stepper_position_sequencer_unit: two-motor half/full-step position sequencer
// Command-driven position, target and coil latch control for two steppers.
// ----------------------------------------------------------------------------
// The unit takes one command beat per clock while the result register drains
// and returns one result beat per command: an accepted command is held in the
// input register, then its result lands in the result register. Throughput is
// one command per cycle unless out_ready holds the result register; the update
// of position, target and coil latches is combinational and sits between
// those two registers. Both motors share one position, one target and
// one coil pattern. A tick moves the position one step toward the target and,
// if it moved, enables the drive and relatches the coils from the half-step
// (bits [2:0]) or full-step (bits [1:0]) table; move-by adds to the target
// modulo 2^POSITION_BITS; go-to loads the target; set-position loads both;
// enable latches the coils; disable clears them. Unused opcodes only report
// state. half_step_mode sits at byte address 0 of the APB port, resets to 1 and
// takes effect at the next latch; write it only while no command is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_position_sequencer_unit
  import sps_pkg::*;
(
  input  wire                         clk,
  input  wire                         rst,

  // APB-style configuration port
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [ADDR_BITS-1:0]        paddr,
  input  wire  [DATA_BITS-1:0]        pwdata,
  output logic [DATA_BITS-1:0]        prdata,
  output logic                        pready,

  // command channel
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [2:0]                  opcode,
  input  wire  signed [FIELD_BITS-1:0] amount,

  // result channel
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [3:0]                  left_coils,
  output logic [3:0]                  right_coils,
  output logic                        enabled_flag,
  output logic                        moving_flag,
  output logic signed [FIELD_BITS-1:0] current_position
);

  // configuration
  logic half_step_mode;

  // input register
  logic                        cmd_valid;
  logic [2:0]                  cmd_opcode;
  logic signed [FIELD_BITS-1:0] cmd_amount;

  // architectural state
  pos_t  position, position_next;
  pos_t  target, target_next;
  logic  drive_on, drive_on_next;
  coil_t left_latch, left_latch_next;
  coil_t right_latch, right_latch_next;

  logic  advance;
  pos_t  amt_ext;
  pos_t  step_pos;
  coil_t pattern;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_step_mode <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_HALF_STEP_MODE) begin
      half_step_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_HALF_STEP_MODE) begin
      prdata[0] = half_step_mode;
    end
  end

  // ---------------------------------------------------------------- handshake
  // Commit the held command whenever the result register is free or drains.
  assign advance  = cmd_valid && (!out_valid || out_ready);
  assign in_ready = !cmd_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_opcode <= opcode;
      cmd_amount <= amount;
    end
  end

  // ---------------------------------------------------------------- update
  // Sign-extend (or wrap) the amount to the position width.
  assign amt_ext = POSITION_BITS'(cmd_amount);

  // One step toward the target; only used when position differs from target.
  assign step_pos = (position > target) ? position - pos_t'(1) : position + pos_t'(1);

  // Coil pattern for the position being latched.
  always_comb begin
    pos_t latch_pos;
    latch_pos = (op_t'(cmd_opcode) == OP_TICK) ? step_pos : position;
    if (half_step_mode) begin
      pattern = half_step_pattern(latch_pos[2:0]);
    end else begin
      pattern = full_step_pattern(latch_pos[1:0]);
    end
  end

  always_comb begin
    position_next    = position;
    target_next      = target;
    drive_on_next    = drive_on;
    left_latch_next  = left_latch;
    right_latch_next = right_latch;
    case (op_t'(cmd_opcode))
      OP_TICK: begin
        if (position != target) begin
          position_next    = step_pos;
          drive_on_next    = 1'b1;
          left_latch_next  = pattern;
          right_latch_next = pattern;
        end
      end
      OP_MOVE_BY: begin
        target_next = target + amt_ext;
      end
      OP_GO_TO: begin
        target_next = amt_ext;
      end
      OP_SET_POS: begin
        target_next   = amt_ext;
        position_next = amt_ext;
      end
      OP_ENABLE: begin
        drive_on_next    = 1'b1;
        left_latch_next  = pattern;
        right_latch_next = pattern;
      end
      OP_DISABLE: begin
        drive_on_next    = 1'b0;
        left_latch_next  = '0;
        right_latch_next = '0;
      end
      default: begin
        // unused opcodes: report state only
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      target      <= '0;
      drive_on    <= 1'b0;
      left_latch  <= '0;
      right_latch <= '0;
    end else if (advance) begin
      position    <= position_next;
      target      <= target_next;
      drive_on    <= drive_on_next;
      left_latch  <= left_latch_next;
      right_latch <= right_latch_next;
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Report the low field bits of the position, zero-filled if narrower.
  always_ff @(posedge clk) begin
    if (advance) begin
      left_coils       <= left_latch_next;
      right_coils      <= right_latch_next;
      enabled_flag     <= drive_on_next;
      moving_flag      <= (position_next != target_next);
      current_position <= FIELD_BITS'(unsigned'(position_next));
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/stepper_position_sequencer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// stepper_position_sequencer_unit_tb: self-checking bench for the sequencer
// Drives command beats through a queue-fed driver, keeps a cycle-free shadow
// of position, target, drive and coil latch, and checks every result beat in
// order while both sides stall at random and the step mode is switched.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module stepper_position_sequencer_unit_tb
  import sps_pkg::*;
();

  // Opcodes the block leaves unused; they must report state and change nothing.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // Coil sequences packed four bits per entry, entry 0 in the low nibble.
  localparam logic [31:0] HALF_SEQ = {4'b0110, 4'b0100, 4'b0101, 4'b0001,
                                      4'b1001, 4'b1000, 4'b1010, 4'b0010};
  localparam logic [15:0] FULL_SEQ = {4'b0100, 4'b0001, 4'b1000, 4'b0010};

  localparam logic [ADDR_BITS-1:0] MODE_ADDR = ADDR_BITS'({REG_HALF_STEP_MODE, 2'b00});

  localparam int IDLE_PCT    = 37;    // chance per cycle that a side idles
  localparam int PHASE_CMDS  = 280;   // random commands per step-mode phase
  localparam int HOLD_AT     = 150;   // result count that starts the long hold-off
  localparam int HOLD_CYCLES = 300;   // length of that hold-off
  localparam int STALL_LIMIT = 4000;  // cycles without any beat before giving up

  typedef struct packed {
    logic [2:0]            op;
    logic [FIELD_BITS-1:0] amt;
  } step_cmd_t;

  typedef struct packed {
    coil_t                 left;
    coil_t                 right;
    logic                  drive;
    logic                  moving;
    logic [FIELD_BITS-1:0] posn;
  } coil_report_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [ADDR_BITS-1:0]         paddr   = '0;
  logic [DATA_BITS-1:0]         pwdata  = '0;
  logic [DATA_BITS-1:0]         prdata;
  logic                         pready;

  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  logic [2:0]                   opcode    = '0;
  logic signed [FIELD_BITS-1:0] amount    = '0;

  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [3:0]                   left_coils;
  logic [3:0]                   right_coils;
  logic                         enabled_flag;
  logic                         moving_flag;
  logic signed [FIELD_BITS-1:0] current_position;

  stepper_position_sequencer_unit dut (.*);

  // --------------------------------------------------------------------------
  // Shadow of the sequencer: one shared position, target and coil pattern.
  // Starts in the reset state; reset is applied only once.
  // --------------------------------------------------------------------------
  pos_t  shaft_pos  = '0;
  pos_t  shaft_tgt  = '0;
  logic  drive_on   = 1'b0;
  coil_t coil_latch = '0;
  logic  half_mode  = 1'b1;

  step_cmd_t    cmd_q[$];      // commands waiting for the driver
  coil_report_t report_q[$];   // predicted result beats, oldest first
  step_cmd_t    next_cmd;
  coil_report_t want;
  int           phase_cmds = 0;
  int           errors = 0;
  int           results_seen = 0;
  int           hold_left = 0;
  logic         held_once = 1'b0;
  logic         steady = 1'b0;   // suppress random idling on both sides
  int           quiet_cycles = 0;

  // Pick the coil pattern for the current position and turn the drive on.
  function automatic void latch_coils();
    drive_on = 1'b1;
    if (half_mode) coil_latch = HALF_SEQ[{shaft_pos[2:0], 2'b00} +: 4];
    else           coil_latch = FULL_SEQ[{shaft_pos[1:0], 2'b00} +: 4];
  endfunction

  // Advance the shadow by one command and return the beat it should produce.
  function automatic coil_report_t apply_command(input logic [2:0] op,
                                                 input logic signed [FIELD_BITS-1:0] amt);
    coil_report_t r;
    pos_t a;
    a = pos_t'(amt);
    case (op)
      OP_TICK: begin
        // an idle tick (position already at target) leaves everything alone
        if (shaft_pos != shaft_tgt) begin
          shaft_pos = (shaft_pos > shaft_tgt) ? shaft_pos - pos_t'(1) : shaft_pos + pos_t'(1);
          latch_coils();
        end
      end
      OP_MOVE_BY: shaft_tgt = shaft_tgt + a;   // wraps modulo the position width
      OP_GO_TO:   shaft_tgt = a;
      OP_SET_POS: begin
        shaft_tgt = a;
        shaft_pos = a;
      end
      OP_ENABLE:  latch_coils();
      OP_DISABLE: begin
        drive_on   = 1'b0;
        coil_latch = '0;
      end
      default: ;
    endcase
    r.left   = coil_latch;
    r.right  = coil_latch;
    r.drive  = drive_on;
    r.moving = (shaft_pos != shaft_tgt);
    r.posn   = shaft_pos[FIELD_BITS-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      errors++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: feed command beats from cmd_q. Valid holds with a steady payload
  // until the beat is taken; the shadow advances on each accepted beat.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) report_q.push_back(apply_command(opcode, amount));
      if (!in_valid || in_ready) begin
        if (cmd_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_cmd = cmd_q.pop_front();
          in_valid <= 1'b1;
          opcode   <= next_cmd.op;
          amount   <= next_cmd.amt;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: take result beats, check against the oldest prediction, and
  // throttle out_ready. Once, hold ready low long enough to back the block up.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $error("result beat with no command outstanding");
          errors++;
        end else begin
          want = report_q.pop_front();
          check_field("left_coils", want.left, left_coils);
          check_field("right_coils", want.right, right_coils);
          check_field("enabled_flag", want.drive, enabled_flag);
          check_field("moving_flag", want.moving, moving_flag);
          check_field("current_position", $signed(want.posn), current_position);
        end
        results_seen++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (results_seen >= HOLD_AT && !held_once) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: give up when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("stepper_position_sequencer_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [FIELD_BITS-1:0] rand_amt();
    return FIELD_BITS'($urandom);
  endfunction

  task automatic push_cmd(input logic [2:0] op, input logic [FIELD_BITS-1:0] amt);
    step_cmd_t c;
    c.op  = op;
    c.amt = amt;
    cmd_q.push_back(c);
    phase_cmds++;
  endtask

  // Any opcode, any amount, the unused codes included.
  task automatic push_noise();
    push_cmd(3'($urandom_range(0, 7)), rand_amt());
  endtask

  // One random block of commands. Most are motion bursts: optionally place the
  // shaft, aim a few steps away, then tick there and a little past.
  task automatic push_block();
    int   kind;
    int   base;
    int   span;
    int   ticks;
    logic placed;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      placed = ($urandom_range(0, 2) == 0);
      base   = 0;
      if (placed) begin
        case ($urandom_range(0, 3))
          0:       base = 32767 - int'($urandom_range(0, 15));
          1:       base = -32768 + int'($urandom_range(0, 15));
          default: base = rand_amt();
        endcase
        push_cmd(OP_SET_POS, FIELD_BITS'(base));
      end
      span = int'($urandom_range(0, 24)) - 12;
      if (placed && $urandom_range(0, 1) == 1) push_cmd(OP_GO_TO, FIELD_BITS'(base + span));
      else                                     push_cmd(OP_MOVE_BY, FIELD_BITS'(span));
      ticks = ((span < 0) ? -span : span) + int'($urandom_range(0, 3));
      repeat (ticks) begin
        if ($urandom_range(0, 9) == 0) push_noise();
        else                           push_cmd(OP_TICK, rand_amt());
      end
    end else if (kind == 6) begin
      push_cmd(OP_ENABLE, rand_amt());
    end else if (kind == 7) begin
      push_cmd(OP_DISABLE, rand_amt());
    end else if (kind == 8) begin
      push_noise();
    end else begin
      // long jump of the target, then a few steps toward it
      push_cmd(OP_MOVE_BY, rand_amt());
      repeat ($urandom_range(1, 6)) push_cmd(OP_TICK, rand_amt());
    end
  endtask

  // Wait until every command has been taken and every result checked, then
  // let the pipeline settle.
  task automatic drain();
    do @(negedge clk);
    while (cmd_q.size() != 0 || in_valid || report_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write half_step_mode over the APB port (setup, then access).
  task automatic write_mode(input logic mode);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= DATA_BITS'(mode);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    half_mode = mode;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    write_mode(1'b1);

    // Directed: idle tick, every opcode, amount extremes, target wrap both
    // ways, stepping up and down, and a tick that re-enables after disable.
    push_cmd(OP_TICK, 16'h7FFF);
    push_cmd(OP_ENABLE, 16'h8000);
    push_cmd(OP_DISABLE, 16'hFFFF);
    push_cmd(OP_SPARE_LO, 16'h0000);
    push_cmd(OP_SPARE_HI, 16'h5A5A);
    push_cmd(OP_SET_POS, 16'h7FFF);
    push_cmd(OP_MOVE_BY, 16'hFFFF);
    push_cmd(OP_TICK, 16'h0000);
    push_cmd(OP_TICK, 16'hA5A5);
    push_cmd(OP_SET_POS, 16'h8000);
    push_cmd(OP_GO_TO, 16'h8001);
    push_cmd(OP_TICK, 16'h0000);
    push_cmd(OP_MOVE_BY, 16'h8000);
    push_cmd(OP_MOVE_BY, 16'h7FFF);
    push_cmd(OP_SET_POS, 16'd5);
    push_cmd(OP_GO_TO, 16'd1);
    repeat (3) push_cmd(OP_TICK, 16'h0000);
    push_cmd(OP_ENABLE, 16'h0000);
    push_cmd(OP_MOVE_BY, 16'd3);
    push_cmd(OP_DISABLE, 16'h0000);
    push_cmd(OP_TICK, 16'hFFFF);
    push_cmd(OP_TICK, 16'h0000);
    drain();

    // Random phases, alternating full-step and half-step drive; the middle
    // one runs with no idling at all.
    for (int ph = 0; ph < 5; ph++) begin
      write_mode((ph % 2) == 1);
      steady = (ph == 2);
      phase_cmds = 0;
      while (phase_cmds < PHASE_CMDS) push_block();
      drain();
    end

    repeat (6) @(posedge clk);
    if (errors == 0) begin
      $display("stepper_position_sequencer_unit: match");
    end else begin
      $display("stepper_position_sequencer_unit: mismatch");
    end
    $finish;
  end

endmodule
